### sv/firq15_pkg.sv
// ----------------------------------------------------------------------------
// firq15_pkg: shared definitions for the q15 fir filter
// widths, tap count, input kind codes, sequencer states and the control
// structs that pass between the top level, the cells and the mac
// ----------------------------------------------------------------------------
package firq15_pkg;

    // number of taps in the ring of cells
    localparam int TAPS = 32;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_IDX_W = 5;
    localparam int ACC_W      = 32;

    // tap counter width
    localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

    // rounding constant and output slice
    localparam logic [ACC_W-1:0] ROUND_HALF = 32'd16384;
    localparam int               OUT_LSB    = 15;

    // input word kinds
    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } firq15_state_t;

    // movement controls shared by every cell
    typedef struct packed {
        logic shift;
        logic rotate;
    } firq15_cell_ctrl_t;

    // controls for the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic mul_en;
    } firq15_mac_ctrl_t;

endpackage

### sv/firq15_cell.sv
// ----------------------------------------------------------------------------
// firq15_cell: one tap of the filter ring
// holds one delayed sample and one tap weight; shifts samples in on a new
// input and rotates both towards the head of the ring during the sum
// ----------------------------------------------------------------------------
module firq15_cell
    import firq15_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  firq15_cell_ctrl_t          ctrl,
    input  logic                       coef_we,
    input  logic signed [COEF_W-1:0]   coef_wdata,
    input  logic signed [SAMPLE_W-1:0] shift_sample,
    input  logic signed [SAMPLE_W-1:0] rot_sample,
    input  logic signed [COEF_W-1:0]   rot_coef,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic signed [COEF_W-1:0]   coef_out
);

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic signed [COEF_W-1:0]   coef_reg;
    logic signed [COEF_W-1:0]   coef_next;

    // next sample: shift in, rotate or hold
    always_comb
    begin
        sample_next = sample_reg;
        if (ctrl.shift)
        begin
            sample_next = shift_sample;
        end
        else if (ctrl.rotate)
        begin
            sample_next = rot_sample;
        end
    end

    // next weight: rotate, write or hold
    always_comb
    begin
        coef_next = coef_reg;
        if (ctrl.rotate)
        begin
            coef_next = rot_coef;
        end
        else if (coef_we)
        begin
            coef_next = coef_wdata;
        end
    end

    // tap storage, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            coef_reg   <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
            coef_reg   <= coef_next;
        end
    end

    assign sample_out = sample_reg;
    assign coef_out   = coef_reg;

endmodule

### sv/firq15_mac.sv
// ----------------------------------------------------------------------------
// firq15_mac: multiply-accumulate at the head of the ring
// registered 16x16 product, wrapping 32-bit accumulator and the rounded
// q15 output slice
// ----------------------------------------------------------------------------
module firq15_mac
    import firq15_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  firq15_mac_ctrl_t           ctrl,
    input  logic signed [SAMPLE_W-1:0] head_sample,
    input  logic signed [COEF_W-1:0]   head_coef,
    output logic signed [SAMPLE_W-1:0] result
);

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;
    logic                    prod_vld_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_next;
    logic [ACC_W-1:0]        rounded;

    // product of the head tap
    assign prod_next = head_sample * head_coef;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mul_en;
        end
    end

    // wrapping accumulation
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(unsigned'(prod_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // round and take bits 30..15, top bit dropped
    assign rounded = acc_reg + ROUND_HALF;
    assign result  = signed'(rounded[OUT_LSB+SAMPLE_W-1:OUT_LSB]);

endmodule

### sv/fir_filter_q15.sv
// ----------------------------------------------------------------------------
// fir_filter_q15: direct-form fir filter on signed q15 samples
// a ring of tap cells rotates samples and weights past one shared
// multiply-accumulate unit; one rounded 16-bit result per sample word
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   input   | in_valid, in_stall | kind, sample, coef_index, coef_value
//   output  | out_valid,out_stall| filtered
//
// a coefficient word writes one tap weight and gives no result
// a sample word passes the accepting idle state, the run state, which rotates
// every tap of the ring past the single mac, the drain state and the done
// state, which loads the result into the output register once it is free
// reset clears all samples and weights and the sequencer; no clearing pass
// the result sits in an output register; a stalled output holds the next
// sample word in its final step, and the input stays stalled until it leaves
// ----------------------------------------------------------------------------
module fir_filter_q15
    import firq15_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         kind,
    input  logic signed [SAMPLE_W-1:0]   sample,
    input  logic [COEF_IDX_W-1:0]        coef_index,
    input  logic signed [COEF_W-1:0]     coef_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [SAMPLE_W-1:0]   filtered
);

    firq15_state_t              state_reg;
    firq15_state_t              state_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] filtered_reg;
    logic                       in_acc;
    logic                       sample_acc;
    logic                       coef_acc;
    logic                       last_tap;
    logic                       out_free;
    logic                       load_out;
    firq15_cell_ctrl_t          cell_ctrl;
    firq15_mac_ctrl_t           mac_ctrl;
    logic signed [SAMPLE_W-1:0] chain_sample [TAPS];
    logic signed [COEF_W-1:0]   chain_coef   [TAPS];
    logic [TAPS-1:0]            coef_we;
    logic signed [SAMPLE_W-1:0] mac_result;

    // handshake decode
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign sample_acc = in_acc && (kind == KIND_SAMPLE);
    assign coef_acc   = in_acc && (kind == KIND_COEF);
    assign last_tap   = (cnt_reg == CNT_W'(TAPS - 1));
    assign out_free   = !out_valid_reg || !out_stall;
    assign load_out   = (state_reg == ST_DONE) && out_free;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (sample_acc)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // controls for the ring and the mac
    assign cell_ctrl.shift  = sample_acc;
    assign cell_ctrl.rotate = (state_reg == ST_RUN);
    assign mac_ctrl.clear   = sample_acc;
    assign mac_ctrl.mul_en  = (state_reg == ST_RUN);

    // ring of tap cells, head at cell 0
    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        if (k < (1 << COEF_IDX_W))
        begin : g_we
            assign coef_we[k] = coef_acc && (coef_index == COEF_IDX_W'(k));
        end
        else
        begin : g_no_we
            assign coef_we[k] = 1'b0;
        end

        firq15_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (cell_ctrl),
            .coef_we      (coef_we[k]),
            .coef_wdata   (coef_value),
            .shift_sample ((k == 0) ? sample : chain_sample[(k + TAPS - 1) % TAPS]),
            .rot_sample   (chain_sample[(k + 1) % TAPS]),
            .rot_coef     (chain_coef[(k + 1) % TAPS]),
            .sample_out   (chain_sample[k]),
            .coef_out     (chain_coef[k])
        );
    end

    // shared multiply-accumulate
    firq15_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (mac_ctrl),
        .head_sample (chain_sample[0]),
        .head_coef   (chain_coef[0]),
        .result      (mac_result)
    );

    // output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            filtered_reg <= mac_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    // a result word appears only after a finished sum
    a_out_from_done : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result word without a finished sum");

    // a sample word starts the ring at the first tap
    a_sample_starts : assert property (@(posedge clk) disable iff (!rst_n)
        sample_acc |=> (state_reg == ST_RUN) && (cnt_reg == '0))
        else $error("sample word did not start the tap sweep");

    // the sweep ends after the last tap
    a_run_ends : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && last_tap |=> (state_reg == ST_DRAIN))
        else $error("tap sweep did not end at the last tap");

    // a coefficient word starts no work
    a_coef_idle : assert property (@(posedge clk) disable iff (!rst_n)
        coef_acc |=> (state_reg == ST_IDLE) && !$rose(out_valid))
        else $error("coefficient word started a sum");

endmodule

### tb/sv/fir_filter_q15_test.sv
// ----------------------------------------------------------------------------
// fir_filter_q15_test: self-checking bench for the q15 fir filter
// a short list of hand-made words (extremes, the wrapping output, weight
// writes) is followed by random coefficient and sample words; every sample
// word is run through a local filter model and the block's filtered words
// are compared in order, with random idling and back-pressure on both sides
// ----------------------------------------------------------------------------
module fir_filter_q15_test;
    import firq15_pkg::*;

    // run shape
    localparam int RANDOM_WORDS = 630;
    localparam int PAUSE_AT     = 300;
    localparam int HOLD_AFTER   = 150;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 2 * (TAPS + 3) + 10;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 30;

    // one word of stimulus, with an optional hand-typed result
    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] smp;
        logic [COEF_IDX_W-1:0]      idx;
        logic signed [COEF_W-1:0]   wt;
        logic                       known;
        logic signed [SAMPLE_W-1:0] known_val;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [COEF_IDX_W-1:0]      coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] filtered;

    // local filter model state
    logic signed [SAMPLE_W-1:0] hist [TAPS];
    logic signed [COEF_W-1:0]   weights [TAPS];
    int                         next_slot;

    // filtered words still owed by the block
    logic signed [SAMPLE_W-1:0] pending_filtered [$];
    stim_row_t                  directed_words [$];

    int failures;
    int results_checked;
    int coef_words;
    int sample_words;
    int input_held;
    int quiet_left;
    int cycle_count;
    bit long_hold_done;

    fir_filter_q15 DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .sample     (sample),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .filtered   (filtered)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t timeout after %0d cycles, %0d filtered words still owed",
                 $time, cycle_count, pending_filtered.size());
        $display("TEST FAILED");
        $finish;
    end

    // model: store one tap weight
    task automatic store_weight(input logic [COEF_IDX_W-1:0] idx,
                                input logic signed [COEF_W-1:0] wt);
        if (idx < TAPS)
            weights[idx] = wt;
    endtask

    // model: shift in one sample and form the rounded, wrapped output
    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
        input logic signed [SAMPLE_W-1:0] smp);
        logic [ACC_W-1:0]        acc;
        logic signed [ACC_W-1:0] prod;
        int                      newest;
        int                      pos;
        newest       = next_slot;
        hist[newest] = smp;
        next_slot    = (newest + 1 >= TAPS) ? 0 : newest + 1;
        acc = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            pos  = (newest + TAPS - k) % TAPS;
            prod = hist[pos] * weights[k];
            acc  = acc + prod;
        end
        acc = acc + ROUND_HALF;
        return acc[OUT_LSB +: SAMPLE_W];
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(15, 4);
        return $urandom_range(60, 20);
    endfunction

    // field value biased towards the extremes
    function automatic logic signed [15:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 16'sh7FFF;
        if (r < 10)
            return 16'sh8000;
        if (r < 13)
            return 16'sh0000;
        if (r < 16)
            return 16'shFFFF;
        if (r < 19)
            return 16'sh0001;
        return 16'($urandom);
    endfunction

    task automatic add_row(input logic k, input logic signed [15:0] smp,
                           input logic [4:0] idx, input logic signed [15:0] wt,
                           input logic known, input logic signed [15:0] known_val);
        stim_row_t row;
        row.kind      = k;
        row.smp       = smp;
        row.idx       = idx;
        row.wt        = wt;
        row.known     = known;
        row.known_val = known_val;
        directed_words.push_back(row);
    endtask

    // offer one word, wait for acceptance, predict, then maybe idle
    task automatic send_word(input stim_row_t row);
        int gap;
        kind       <= row.kind;
        sample     <= row.smp;
        coef_index <= row.idx;
        coef_value <= row.wt;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            input_held++;
            @(posedge clk);
        end
        if (row.kind == KIND_SAMPLE)
        begin
            sample_words++;
            if (row.known)
            begin
                void'(filter_sample(row.smp));
                pending_filtered.push_back(row.known_val);
            end
            else
                pending_filtered.push_back(filter_sample(row.smp));
        end
        else
        begin
            coef_words++;
            store_weight(row.idx, row.wt);
        end
        // idle, except in quiet stretches
        if (quiet_left > 0)
        begin
            quiet_left--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(99) < 4)
                quiet_left = $urandom_range(60, 30);
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // compare one filtered word with the oldest prediction
    task automatic check_filtered(input logic signed [SAMPLE_W-1:0] got);
        logic signed [SAMPLE_W-1:0] want;
        if (pending_filtered.size() == 0)
        begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t filtered word %0d with nothing expected", $time, got);
        end
        else
        begin
            want = pending_filtered.pop_front();
            results_checked++;
            if (got !== want)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t filtered mismatch: expected %0d, actual %0d",
                             $time, want, got);
            end
        end
    endtask

    // output side: checking and back-pressure, with one long hold
    initial
    begin : result_side
        int free_left;
        int stall_left;
        int hold_left;
        out_stall      = 1'b0;
        free_left      = 0;
        stall_left     = 0;
        hold_left      = 0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                check_filtered(filtered);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!long_hold_done && results_checked >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                out_stall      <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                free_left  = ($urandom_range(99) < 10) ? $urandom_range(200, 60)
                                                      : $urandom_range(6);
                stall_left = pick_gap();
                out_stall  <= 1'b0;
            end
        end
    end

    // input side: reset, directed words, random words, drain and report
    initial
    begin : word_side
        stim_row_t row;
        int        n;
        int        r;
        int        mode;
        bit        paused;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        kind            = KIND_COEF;
        sample          = '0;
        coef_index      = '0;
        coef_value      = '0;
        failures        = 0;
        results_checked = 0;
        coef_words      = 0;
        sample_words    = 0;
        input_held      = 0;
        quiet_left      = 0;
        next_slot       = 0;
        paused          = 1'b0;
        for (int i = 0; i < TAPS; i++)
        begin
            hist[i]    = '0;
            weights[i] = '0;
        end

        // hand-made words: zero weights after reset, then the wrapping cases
        add_row(KIND_SAMPLE, 16'sh7FFF, 5'd31, 16'shFFFF, 1'b1, 16'sh0000);
        add_row(KIND_SAMPLE, 16'sh8000, 5'd0,  16'sh0000, 1'b1, 16'sh0000);
        add_row(KIND_COEF,   16'sh0000, 5'd0,  16'sh8000, 1'b0, 16'sh0000);
        // full-scale square sets bit 30, which lands in the sign bit, and wraps negative
        add_row(KIND_SAMPLE, 16'sh8000, 5'd31, 16'sh7FFF, 1'b1, 16'sh8000);
        add_row(KIND_COEF,   16'shFFFF, 5'd1,  16'sh8000, 1'b0, 16'sh0000);
        // two full-scale products reach bit 31, which is dropped
        add_row(KIND_SAMPLE, 16'sh8000, 5'd0,  16'sh0000, 1'b1, 16'sh0000);
        add_row(KIND_COEF,   16'sh0000, 5'd31, 16'sh7FFF, 1'b0, 16'sh0000);
        add_row(KIND_COEF,   16'sh5A5A, 5'd0,  16'sh7FFF, 1'b0, 16'sh0000);
        add_row(KIND_COEF,   16'shA5A5, 5'd1,  16'sh0000, 1'b0, 16'sh0000);
        add_row(KIND_SAMPLE, 16'sh7FFF, 5'd0,  16'sh0000, 1'b0, 16'sh0000);
        add_row(KIND_COEF,   16'sh0000, 5'd5,  16'sh5555, 1'b0, 16'sh0000);
        add_row(KIND_COEF,   16'shFFFF, 5'd10, 16'shAAAA, 1'b0, 16'sh0000);
        add_row(KIND_SAMPLE, 16'sh5555, 5'd31, 16'shFFFF, 1'b0, 16'sh0000);
        add_row(KIND_SAMPLE, 16'shAAAA, 5'd0,  16'sh0000, 1'b0, 16'sh0000);
        add_row(KIND_SAMPLE, 16'sh0000, 5'd21, 16'sh1234, 1'b0, 16'sh0000);
        add_row(KIND_SAMPLE, 16'sh0001, 5'd10, 16'shEDCB, 1'b0, 16'sh0000);
        add_row(KIND_SAMPLE, 16'shFFFF, 5'd0,  16'sh0000, 1'b0, 16'sh0000);
        add_row(KIND_COEF,   16'sh7FFF, 5'd31, 16'shFFFF, 1'b0, 16'sh0000);
        add_row(KIND_COEF,   16'sh8000, 5'd0,  16'sh0001, 1'b0, 16'sh0000);
        add_row(KIND_SAMPLE, 16'sh4000, 5'd0,  16'sh0000, 1'b0, 16'sh0000);
        add_row(KIND_SAMPLE, 16'shC000, 5'd31, 16'shFFFF, 1'b0, 16'sh0000);
        add_row(KIND_SAMPLE, 16'sh7FFF, 5'd0,  16'sh0000, 1'b0, 16'sh0000);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_words[i])
            send_word(directed_words[i]);

        // random words, with the odd burst that rewrites every tap
        n = 0;
        while (n < RANDOM_WORDS)
        begin
            // sender waits for the block to empty once
            if (!paused && n >= PAUSE_AT)
            begin
                paused   = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_filtered.size() != 0)
                    @(posedge clk);
            end
            r = $urandom_range(199);
            if (r < 3)
            begin
                mode = $urandom_range(2);
                for (int t = 0; t < TAPS; t++)
                begin
                    row.kind      = KIND_COEF;
                    row.smp       = SAMPLE_W'($urandom);
                    row.idx       = COEF_IDX_W'(t);
                    row.known     = 1'b0;
                    row.known_val = '0;
                    if (mode == 0)
                        row.wt = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
                    else if (mode == 1)
                        row.wt = 16'sh8000;
                    else
                        row.wt = pick_value();
                    send_word(row);
                    n++;
                end
            end
            else
            begin
                row.kind      = (r < 50) ? KIND_COEF : KIND_SAMPLE;
                row.known     = 1'b0;
                row.known_val = '0;
                if (row.kind == KIND_COEF)
                begin
                    row.smp = SAMPLE_W'($urandom);
                    row.idx = COEF_IDX_W'($urandom);
                    row.wt  = pick_value();
                end
                else
                begin
                    row.smp = pick_value();
                    row.idx = COEF_IDX_W'($urandom);
                    row.wt  = COEF_W'($urandom);
                end
                send_word(row);
                n++;
            end
        end

        // drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_filtered.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d coefficient words and %0d sample words sent, %0d filtered words checked",
                 coef_words, sample_words, results_checked);
        $display("input held off for %0d cycles, long output hold %0s, one full drain pause",
                 input_held, long_hold_done ? "done" : "not reached");
        if (failures == 0 && pending_filtered.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/firq15_pkg.sv
sv/firq15_cell.sv
sv/firq15_mac.sv
sv/fir_filter_q15.sv
tb/sv/fir_filter_q15_test.sv
